// ===== rtl/staircase_job_scheduler_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef STAIRCASE_JOB_SCHEDULER_MACROS_SVH
`define STAIRCASE_JOB_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SJS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sjs_pkg.sv =====
package sjs_pkg;

   // Field widths of the command and result transactions.
   localparam int PID_W   = 16;
   localparam int TIME_W  = 16;
   localparam int SLOT_W  = 6;
   localparam int PRIO_W  = 4;
   localparam int COUNT_W = 7;
   localparam int CMD_W   = 2;
   localparam int CSR_INDEX_W = 2;

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD     = 2'd0,
      CMD_REQUEUE = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_SELECT  = 2'd3
   } cmd_type;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_QUANTUM      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_BUDGET = 2'd1;

   // Reset values and limits.
   localparam logic [TIME_W-1:0]  QUANTUM_RESET = 16'd100;
   localparam logic [TIME_W-1:0]  BUDGET_RESET  = 16'd500;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd127;

endpackage

// ===== rtl/staircase_job_scheduler.sv =====
// Staircase multilevel job scheduler.
// Commands enter on the req_ channel (valid/ready); every command returns exactly one
// transaction on the rsp_ channel. Add, requeue and remove return all-zero results;
// select returns the chosen job, its grant and whether the banks were swapped.
// The csr_ channel writes quantum (index 0) and level_budget (index 1); it is always
// ready and is meant to be written only while the scheduler is idle.
// One command is worked on at a time. The job table and the queue table each sit in
// a single-port-write memory with a registered read. Select scans one level per cycle
// and, when the banks swap, repeats the scan on the newly active bank.
// The next command is taken as soon as the result is handed to the output register,
// so a stalled receiver only delays a command that finishes while a result still waits.
// Reset is synchronous and active high: it empties all queues, marks every budget as
// level_budget's reset value, selects bank zero and restores the register defaults.
// No clearing pass is needed; queue entries carry valid and refill flags in flip-flops.
module staircase_job_scheduler #(
   parameter int LEVELS   = 20,
   parameter int MAX_JOBS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sjs_pkg::CMD_W-1:0]        req_cmd,
   input  logic [sjs_pkg::PID_W-1:0]        req_pid,
   input  logic [sjs_pkg::PRIO_W-1:0]       req_priority_req,
   input  logic [sjs_pkg::SLOT_W-1:0]       req_slot,
   input  logic [sjs_pkg::TIME_W-1:0]       req_remaining_time,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_picked,
   output logic [sjs_pkg::PID_W-1:0]        rsp_pid_res,
   output logic [sjs_pkg::SLOT_W-1:0]       rsp_chosen_slot,
   output logic [sjs_pkg::TIME_W-1:0]       rsp_grant,
   output logic                             rsp_swapped,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sjs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sjs_pkg::TIME_W-1:0]       csr_data
);

`include "staircase_job_scheduler_macros.svh"

   localparam int NQ = 2 * LEVELS;
   localparam int LW = $clog2(LEVELS);
   localparam int QW = $clog2(NQ);
   localparam int JW = $clog2(MAX_JOBS);

   typedef struct packed {
      logic [sjs_pkg::PID_W-1:0]  pid;
      logic [sjs_pkg::TIME_W-1:0] slice;
      logic [sjs_pkg::TIME_W-1:0] grant;
      logic [LW-1:0]              home;
      logic [LW-1:0]              level;
      logic [JW-1:0]              link;
   } job_word_type;

   typedef struct packed {
      logic [sjs_pkg::TIME_W-1:0]  budget;
      logic [sjs_pkg::COUNT_W-1:0] count;
      logic [JW-1:0]               head;
      logic [JW-1:0]               tail;
   } queue_word_type;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_JOB_RD   = 12'b0000_0000_0010,
      ST_JOB_CHK  = 12'b0000_0000_0100,
      ST_Q_UPD    = 12'b0000_0000_1000,
      ST_ENQ_RD   = 12'b0000_0001_0000,
      ST_ENQ_CHK  = 12'b0000_0010_0000,
      ST_LINK_WR  = 12'b0000_0100_0000,
      ST_SEL_RD   = 12'b0000_1000_0000,
      ST_SCAN     = 12'b0001_0000_0000,
      ST_SEL_PICK = 12'b0010_0000_0000,
      ST_DONE     = 12'b0100_0000_0000,
      ST_SPARE    = 12'b1000_0000_0000
   } state_type;

   // Level and queue index helpers.
   function automatic logic [LW-1:0] clamp_level(input logic [LW-1:0] l);
      return (int'(l) >= LEVELS) ? LW'(LEVELS - 1) : l;
   endfunction

   function automatic logic [LW-1:0] next_level(input logic [LW-1:0] l);
      return (int'(l) >= LEVELS - 1) ? LW'(LEVELS - 1) : l + LW'(1);
   endfunction

   function automatic logic [LW-1:0] add_level(input logic [sjs_pkg::PRIO_W-1:0] p);
      logic [5:0] dbl;
      dbl = (p == '0) ? 6'd0 : {1'b0, p - 4'd1, 1'b0};
      return (int'(dbl) >= LEVELS) ? LW'(LEVELS - 1) : LW'(dbl);
   endfunction

   function automatic logic [QW-1:0] qidx(input logic bank, input logic [LW-1:0] l);
      return bank ? QW'(LEVELS) + QW'(clamp_level(l)) : QW'(clamp_level(l));
   endfunction

   function automatic logic [sjs_pkg::TIME_W-1:0] sat_sub(
      input logic [sjs_pkg::TIME_W-1:0] a,
      input logic [sjs_pkg::TIME_W-1:0] b
   );
      return (a > b) ? a - b : '0;
   endfunction

   // Control and configuration state.
   state_type                       state_ff, state_in;
   logic [sjs_pkg::TIME_W-1:0]      quantum_ff;
   logic [sjs_pkg::TIME_W-1:0]      level_budget_ff;
   logic                            bank_ff, bank_in;
   logic [NQ-1:0]                   q_valid_ff;
   logic [NQ-1:0]                   q_fresh_ff;
   logic [1:0][sjs_pkg::TIME_W-1:0] refill_ff;
   logic                            swap_go;

   // Captured command fields and working registers.
   sjs_pkg::cmd_type                cmd_ff, cmd_in;
   logic [sjs_pkg::PID_W-1:0]       pid_ff, pid_in;
   logic [sjs_pkg::PRIO_W-1:0]      prio_ff, prio_in;
   logic [JW-1:0]                   slot_ff, slot_in;
   logic [sjs_pkg::TIME_W-1:0]      rem_ff, rem_in;
   job_word_type                    jw_ff, jw_in;
   queue_word_type                  qw_ff, qw_in;
   logic [QW-1:0]                   target_q_ff, target_q_in;
   logic [JW-1:0]                   tail_ff, tail_in;
   logic [LW-1:0]                   scan_ff, scan_in;
   logic                            swapped_ff, swapped_in;

   // Pending result and output register.
   logic                            res_picked_ff, res_picked_in;
   logic [sjs_pkg::PID_W-1:0]       res_pid_ff, res_pid_in;
   logic [sjs_pkg::SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic [sjs_pkg::TIME_W-1:0]      res_grant_ff, res_grant_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_picked_ff;
   logic [sjs_pkg::PID_W-1:0]       rsp_pid_ff;
   logic [sjs_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic [sjs_pkg::TIME_W-1:0]      rsp_grant_ff;
   logic                            rsp_swapped_ff;
   logic                            rsp_load;

   // Memory ports.
   job_word_type                    job_mem [MAX_JOBS];
   queue_word_type                  queue_mem [NQ];
   logic                            jm_we;
   logic [JW-1:0]                   jm_wa, jm_ra;
   job_word_type                    jm_wd;
   job_word_type                    job_rd_ff;
   logic                            qm_we;
   logic [QW-1:0]                   qm_wa, qm_ra;
   queue_word_type                  qm_wd;
   queue_word_type                  queue_rd_ff;
   logic                            q_valid_rd_ff;
   logic                            q_fresh_rd_ff;
   logic [sjs_pkg::TIME_W-1:0]      q_refill_rd_ff;

   // Derived values.
   logic [sjs_pkg::COUNT_W-1:0]     eff_count;
   logic [sjs_pkg::TIME_W-1:0]      eff_budget;
   logic [sjs_pkg::TIME_W-1:0]      used_time;
   logic [sjs_pkg::TIME_W-1:0]      new_slice;
   logic [LW-1:0]                   new_level;
   logic [sjs_pkg::TIME_W-1:0]      min_sb;
   logic [sjs_pkg::TIME_W-1:0]      pick_grant;
   logic                            slot_ok;
   logic                            scan_hit;

   // Job table memory.
   always_ff @(posedge clock) begin
      if (jm_we) begin
         job_mem[jm_wa] <= jm_wd;
      end
      job_rd_ff <= job_mem[jm_ra];
   end

   // Queue table memory, with the per-entry flags sampled alongside the read.
   always_ff @(posedge clock) begin
      if (qm_we) begin
         queue_mem[qm_wa] <= qm_wd;
      end
      queue_rd_ff    <= queue_mem[qm_ra];
      q_valid_rd_ff  <= q_valid_ff[qm_ra];
      q_fresh_rd_ff  <= q_fresh_ff[qm_ra];
      q_refill_rd_ff <= refill_ff[qm_ra >= QW'(LEVELS)];
   end

   // An empty or unwritten queue reads as zero jobs; a refilled one as its bank's refill.
   assign eff_count  = q_valid_rd_ff ? queue_rd_ff.count : '0;
   assign eff_budget = q_fresh_rd_ff ? q_refill_rd_ff : queue_rd_ff.budget;

   // Requeue and remove charges.
   assign used_time = (cmd_ff == sjs_pkg::CMD_REMOVE) ? jw_ff.grant
                                                      : sat_sub(jw_ff.grant, rem_ff);
   assign new_slice = sat_sub(jw_ff.slice, used_time);
   assign new_level = (new_slice == '0) ? clamp_level(jw_ff.home) : next_level(jw_ff.level);

   // Grant is the smallest of slice, level budget and quantum.
   assign min_sb     = (qw_ff.budget < job_rd_ff.slice) ? qw_ff.budget : job_rd_ff.slice;
   assign pick_grant = (quantum_ff < min_sb) ? quantum_ff : min_sb;

   assign slot_ok  = int'(req_slot) < MAX_JOBS;
   assign scan_hit = (eff_budget != '0) && (eff_count != '0);

   // Command sequencer.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pid_in        = pid_ff;
      prio_in       = prio_ff;
      slot_in       = slot_ff;
      rem_in        = rem_ff;
      jw_in         = jw_ff;
      qw_in         = qw_ff;
      target_q_in   = target_q_ff;
      tail_in       = tail_ff;
      scan_in       = scan_ff;
      swapped_in    = swapped_ff;
      bank_in       = bank_ff;
      res_picked_in = res_picked_ff;
      res_pid_in    = res_pid_ff;
      res_slot_in   = res_slot_ff;
      res_grant_in  = res_grant_ff;
      swap_go       = 1'b0;
      rsp_load      = 1'b0;
      jm_we         = 1'b0;
      jm_wa         = slot_ff;
      jm_wd         = job_rd_ff;
      jm_ra         = slot_ff;
      qm_we         = 1'b0;
      qm_wa         = target_q_ff;
      qm_wd         = '{budget: eff_budget, count: eff_count,
                        head: queue_rd_ff.head, tail: queue_rd_ff.tail};
      qm_ra         = target_q_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = sjs_pkg::cmd_type'(req_cmd);
               pid_in        = req_pid;
               prio_in       = req_priority_req;
               slot_in       = JW'(req_slot);
               rem_in        = req_remaining_time;
               swapped_in    = 1'b0;
               res_picked_in = 1'b0;
               res_pid_in    = '0;
               res_slot_in   = '0;
               res_grant_in  = '0;
               if (sjs_pkg::cmd_type'(req_cmd) == sjs_pkg::CMD_SELECT) begin
                  state_in = ST_SEL_RD;
               end else if (!slot_ok) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_JOB_RD;
               end
            end
         end

         ST_JOB_RD: begin
            jm_ra    = slot_ff;
            state_in = ST_JOB_CHK;
         end

         // Add writes the new job, keeping its link; the others look up its queue.
         ST_JOB_CHK: begin
            jw_in = job_rd_ff;
            if (cmd_ff == sjs_pkg::CMD_ADD) begin
               jm_we       = 1'b1;
               jm_wa       = slot_ff;
               jm_wd       = '{pid: pid_ff, slice: quantum_ff, grant: '0,
                               home: add_level(prio_ff), level: add_level(prio_ff),
                               link: job_rd_ff.link};
               target_q_in = qidx(bank_ff, add_level(prio_ff));
               state_in    = ST_ENQ_RD;
            end else begin
               target_q_in = qidx(bank_ff, job_rd_ff.level);
               qm_ra       = qidx(bank_ff, job_rd_ff.level);
               state_in    = ST_Q_UPD;
            end
         end

         // Charge the level budget; requeue also updates the job and moves it.
         ST_Q_UPD: begin
            qm_we        = 1'b1;
            qm_wa        = target_q_ff;
            qm_wd.budget = sat_sub(eff_budget, used_time);
            if (cmd_ff == sjs_pkg::CMD_REQUEUE) begin
               jm_we       = 1'b1;
               jm_wa       = slot_ff;
               jm_wd       = jw_ff;
               jm_wd.slice = (new_slice == '0) ? quantum_ff : new_slice;
               jm_wd.level = new_level;
               target_q_in = qidx(!bank_ff, new_level);
               state_in    = ST_ENQ_RD;
            end else begin
               state_in = ST_DONE;
            end
         end

         ST_ENQ_RD: begin
            qm_ra    = target_q_ff;
            state_in = ST_ENQ_CHK;
         end

         // Append to the tail; a full queue drops the transaction's job.
         ST_ENQ_CHK: begin
            if (eff_count == sjs_pkg::COUNT_MAX) begin
               state_in = ST_DONE;
            end else begin
               qm_we       = 1'b1;
               qm_wa       = target_q_ff;
               qm_wd.count = eff_count + 7'd1;
               qm_wd.tail  = slot_ff;
               if (eff_count == '0) begin
                  qm_wd.head = slot_ff;
                  state_in   = ST_DONE;
               end else begin
                  jm_ra    = queue_rd_ff.tail;
                  tail_in  = queue_rd_ff.tail;
                  state_in = ST_LINK_WR;
               end
            end
         end

         ST_LINK_WR: begin
            jm_we      = 1'b1;
            jm_wa      = tail_ff;
            jm_wd      = job_rd_ff;
            jm_wd.link = slot_ff;
            state_in   = ST_DONE;
         end

         ST_SEL_RD: begin
            qm_ra    = qidx(bank_ff, '0);
            scan_in  = '0;
            state_in = ST_SCAN;
         end

         // One level per cycle; the read of the next level is issued while checking.
         ST_SCAN: begin
            if (scan_hit) begin
               qw_in       = '{budget: eff_budget, count: eff_count,
                               head: queue_rd_ff.head, tail: queue_rd_ff.tail};
               target_q_in = qidx(bank_ff, scan_ff);
               jm_ra       = queue_rd_ff.head;
               state_in    = ST_SEL_PICK;
            end else if (int'(scan_ff) == LEVELS - 1) begin
               if (!swapped_ff) begin
                  swap_go    = 1'b1;
                  bank_in    = !bank_ff;
                  swapped_in = 1'b1;
                  state_in   = ST_SEL_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               scan_in = scan_ff + LW'(1);
               qm_ra   = qidx(bank_ff, scan_ff + LW'(1));
            end
         end

         // Dequeue the head job and record its grant.
         ST_SEL_PICK: begin
            qm_we         = 1'b1;
            qm_wa         = target_q_ff;
            qm_wd         = qw_ff;
            qm_wd.count   = qw_ff.count - 7'd1;
            qm_wd.head    = job_rd_ff.link;
            jm_we         = 1'b1;
            jm_wa         = qw_ff.head;
            jm_wd         = job_rd_ff;
            jm_wd.grant   = pick_grant;
            res_picked_in = 1'b1;
            res_pid_in    = job_rd_ff.pid;
            res_slot_in   = sjs_pkg::SLOT_W'(qw_ff.head);
            res_grant_in  = pick_grant;
            state_in      = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         bank_ff         <= 1'b0;
         quantum_ff      <= sjs_pkg::QUANTUM_RESET;
         level_budget_ff <= sjs_pkg::BUDGET_RESET;
         q_valid_ff      <= '0;
         q_fresh_ff      <= '1;
         refill_ff       <= {sjs_pkg::BUDGET_RESET, sjs_pkg::BUDGET_RESET};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bank_ff      <= bank_in;
         if (csr_valid && (csr_index == sjs_pkg::CSR_QUANTUM)) begin
            quantum_ff <= csr_data;
         end
         if (csr_valid && (csr_index == sjs_pkg::CSR_LEVEL_BUDGET)) begin
            level_budget_ff <= csr_data;
         end
         // A written queue entry holds its own count and budget from then on.
         if (qm_we) begin
            q_valid_ff[qm_wa] <= 1'b1;
            q_fresh_ff[qm_wa] <= 1'b0;
         end
         // A swap refills every level of the newly active bank at once.
         if (swap_go) begin
            refill_ff[!bank_ff] <= level_budget_ff;
            for (int l = 0; l < LEVELS; l++) begin
               q_fresh_ff[qidx(!bank_ff, LW'(l))] <= 1'b1;
            end
         end
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pid_ff        <= pid_in;
      prio_ff       <= prio_in;
      slot_ff       <= slot_in;
      rem_ff        <= rem_in;
      jw_ff         <= jw_in;
      qw_ff         <= qw_in;
      target_q_ff   <= target_q_in;
      tail_ff       <= tail_in;
      scan_ff       <= scan_in;
      swapped_ff    <= swapped_in;
      res_picked_ff <= res_picked_in;
      res_pid_ff    <= res_pid_in;
      res_slot_ff   <= res_slot_in;
      res_grant_ff  <= res_grant_in;
      if (rsp_load) begin
         rsp_picked_ff  <= res_picked_ff;
         rsp_pid_ff     <= res_pid_ff;
         rsp_slot_ff    <= res_slot_ff;
         rsp_grant_ff   <= res_grant_ff;
         rsp_swapped_ff <= swapped_ff;
      end
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_picked      = rsp_picked_ff;
   assign rsp_pid_res     = rsp_pid_ff;
   assign rsp_chosen_slot = rsp_slot_ff;
   assign rsp_grant       = rsp_grant_ff;
   assign rsp_swapped     = rsp_swapped_ff;

   // A select swaps the banks at most once.
   `SJS_ASSERT_NOW(a_single_swap, clock, reset, swap_go, !swapped_ff, "second bank swap in one select")

   // A swap flips the bank and restarts the scan.
   `SJS_ASSERT_NEXT(a_swap_restart, clock, reset, swap_go, (state_ff == ST_SEL_RD) && (bank_ff != $past(bank_ff)), "swap did not restart the scan")

   // The picked queue must have jobs and budget.
   `SJS_ASSERT_NOW(a_pick_ok, clock, reset, state_ff == ST_SEL_PICK, (qw_ff.count != '0) && (qw_ff.budget != '0), "picked an empty or exhausted level")

   // Handing off a result returns the sequencer to idle with the output full.
   `SJS_ASSERT_NEXT(a_result_out, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "result hand-off lost")

endmodule

// ===== bench/tb_staircase_job_scheduler.sv =====
`timescale 1ns / 1ps

module tb_staircase_job_scheduler;

   localparam int NUM_LEVELS = 20;
   localparam int NUM_JOBS   = 64;
   localparam int NUM_QUEUES = 2 * NUM_LEVELS;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 136;

   // One select outcome (all zero for add, requeue and remove).
   typedef struct packed {
      logic                       picked;
      logic [sjs_pkg::PID_W-1:0]  pid;
      logic [sjs_pkg::SLOT_W-1:0] slot;
      logic [sjs_pkg::TIME_W-1:0] grant;
      logic                       swapped;
   } sched_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   sjs_pkg::cmd_type                req_cmd;
   logic [sjs_pkg::PID_W-1:0]       req_pid;
   logic [sjs_pkg::PRIO_W-1:0]      req_priority_req;
   logic [sjs_pkg::SLOT_W-1:0]      req_slot;
   logic [sjs_pkg::TIME_W-1:0]      req_remaining_time;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_picked;
   logic [sjs_pkg::PID_W-1:0]       rsp_pid_res;
   logic [sjs_pkg::SLOT_W-1:0]      rsp_chosen_slot;
   logic [sjs_pkg::TIME_W-1:0]      rsp_grant;
   logic                            rsp_swapped;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [sjs_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sjs_pkg::TIME_W-1:0]      csr_data;

   int error_count = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   logic [sjs_pkg::SLOT_W-1:0] running_slots[$];

   staircase_job_scheduler dut (.*);

   // Print one line per mismatch and count it.
   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Scheduler state mirror and the queue of outcomes still due from the block.
   class sched_scoreboard;
      logic [sjs_pkg::TIME_W-1:0] quantum = sjs_pkg::QUANTUM_RESET;
      logic [sjs_pkg::TIME_W-1:0] level_budget = sjs_pkg::BUDGET_RESET;
      logic [sjs_pkg::PID_W-1:0]  job_pid[NUM_JOBS];
      logic [sjs_pkg::TIME_W-1:0] job_slice[NUM_JOBS];
      logic [sjs_pkg::TIME_W-1:0] job_grant[NUM_JOBS];
      int                         job_home[NUM_JOBS];
      int                         job_lvl[NUM_JOBS];
      logic [sjs_pkg::SLOT_W-1:0] job_link[NUM_JOBS];
      logic [sjs_pkg::SLOT_W-1:0] q_head[NUM_QUEUES];
      logic [sjs_pkg::SLOT_W-1:0] q_tail[NUM_QUEUES];
      int                         q_count[NUM_QUEUES];
      logic [sjs_pkg::TIME_W-1:0] q_budget[NUM_QUEUES];
      bit                         bank;
      sched_result_type           due[$];

      function new();
         for (int i = 0; i < NUM_JOBS; i++) begin
            job_pid[i] = '0; job_slice[i] = '0; job_grant[i] = '0;
            job_home[i] = 0; job_lvl[i] = 0; job_link[i] = '0;
         end
         for (int q = 0; q < NUM_QUEUES; q++) begin
            q_head[q] = '0; q_tail[q] = '0; q_count[q] = 0;
            q_budget[q] = sjs_pkg::BUDGET_RESET;
         end
         bank = 0;
      endfunction

      function int clamp(int l);
         return (l < NUM_LEVELS) ? l : NUM_LEVELS - 1;
      endfunction

      function int qnum(bit b, int l);
         return b * NUM_LEVELS + clamp(l);
      endfunction

      function logic [sjs_pkg::TIME_W-1:0] sat_sub(logic [sjs_pkg::TIME_W-1:0] a,
                                                   logic [sjs_pkg::TIME_W-1:0] b);
         return (a > b) ? a - b : '0;
      endfunction

      // A full queue drops the new entry.
      function void push_job(int q, logic [sjs_pkg::SLOT_W-1:0] s);
         if (q_count[q] >= sjs_pkg::COUNT_MAX) return;
         if (q_count[q] == 0) q_head[q] = s;
         else job_link[q_tail[q]] = s;
         q_tail[q] = s;
         q_count[q]++;
      endfunction

      function int first_ready_level();
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (q_budget[qnum(bank, l)] != 0 && q_count[qnum(bank, l)] != 0) return l;
         end
         return -1;
      endfunction

      function void write_reg(logic [sjs_pkg::CSR_INDEX_W-1:0] idx,
                              logic [sjs_pkg::TIME_W-1:0] val);
         if (idx == sjs_pkg::CSR_QUANTUM) quantum = val;
         else if (idx == sjs_pkg::CSR_LEVEL_BUDGET) level_budget = val;
      endfunction

      // Predict the outcome of one accepted command transaction.
      function void note_command(sjs_pkg::cmd_type c, logic [sjs_pkg::PID_W-1:0] pid,
                                 logic [sjs_pkg::PRIO_W-1:0] prio,
                                 logic [sjs_pkg::SLOT_W-1:0] s,
                                 logic [sjs_pkg::TIME_W-1:0] rem);
         sched_result_type r;
         logic [sjs_pkg::TIME_W-1:0] used, g;
         int l, q;
         logic [sjs_pkg::SLOT_W-1:0] j;
         r = '0;
         case (c)
            sjs_pkg::CMD_ADD: begin
               l = clamp(2 * ((prio > 0) ? prio - 1 : 0));
               job_pid[s] = pid;
               job_slice[s] = quantum;
               job_grant[s] = '0;
               job_home[s] = l;
               job_lvl[s] = l;
               push_job(qnum(bank, l), s);
            end
            sjs_pkg::CMD_REQUEUE: begin
               used = sat_sub(job_grant[s], rem);
               q = qnum(bank, job_lvl[s]);
               q_budget[q] = sat_sub(q_budget[q], used);
               job_slice[s] = sat_sub(job_slice[s], used);
               // A used-up slice sends the job home with a fresh quantum.
               if (job_slice[s] == 0) begin
                  job_lvl[s] = clamp(job_home[s]);
                  job_slice[s] = quantum;
               end else begin
                  job_lvl[s] = clamp(job_lvl[s] + 1);
               end
               push_job(qnum(!bank, job_lvl[s]), s);
            end
            sjs_pkg::CMD_REMOVE: begin
               q = qnum(bank, job_lvl[s]);
               q_budget[q] = sat_sub(q_budget[q], job_grant[s]);
            end
            default: begin
               l = first_ready_level();
               // Nothing qualifies: swap banks once and refill the new budgets.
               if (l < 0) begin
                  bank = !bank;
                  for (int k = 0; k < NUM_LEVELS; k++) q_budget[qnum(bank, k)] = level_budget;
                  r.swapped = 1'b1;
                  l = first_ready_level();
               end
               if (l >= 0) begin
                  q = qnum(bank, l);
                  j = q_head[q];
                  g = job_slice[j];
                  if (q_budget[q] < g) g = q_budget[q];
                  if (quantum < g) g = quantum;
                  q_head[q] = job_link[j];
                  q_count[q]--;
                  job_grant[j] = g;
                  r.picked = 1'b1;
                  r.pid = job_pid[j];
                  r.slot = j;
                  r.grant = g;
               end
            end
         endcase
         due.push_back(r);
      endfunction

      // Compare one accepted result transaction with the oldest prediction.
      task check_result(sched_result_type got);
         sched_result_type want;
         if (due.size() == 0) begin
            report_mismatch("unexpected result", got.picked, 0);
            return;
         end
         want = due.pop_front();
         if (got.picked !== want.picked) report_mismatch("picked", got.picked, want.picked);
         if (got.pid !== want.pid) report_mismatch("pid_res", got.pid, want.pid);
         if (got.slot !== want.slot) report_mismatch("chosen_slot", got.slot, want.slot);
         if (got.grant !== want.grant) report_mismatch("grant", got.grant, want.grant);
         if (got.swapped !== want.swapped)
            report_mismatch("swapped", got.swapped, want.swapped);
      endtask
   endclass

   sched_scoreboard sb = new();

   // Clock.
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Observe all three channels mid-cycle; the handshake completes at the next rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result({rsp_picked, rsp_pid_res, rsp_chosen_slot, rsp_grant, rsp_swapped});
         if (rsp_picked) running_slots.push_back(rsp_chosen_slot);
      end
      if (!reset && req_valid && req_ready)
         sb.note_command(req_cmd, req_pid, req_priority_req, req_slot, req_remaining_time);
      if (!reset && csr_valid && csr_ready) sb.write_reg(csr_index, csr_data);
   end

   // Result receiver: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Offer one command and return at the edge where it is accepted.
   task automatic send_command(sjs_pkg::cmd_type c, logic [sjs_pkg::PID_W-1:0] pid,
                               logic [sjs_pkg::PRIO_W-1:0] prio,
                               logic [sjs_pkg::SLOT_W-1:0] s,
                               logic [sjs_pkg::TIME_W-1:0] rem);
      bit taken;
      req_valid <= 1'b1;
      req_cmd <= c;
      req_pid <= pid;
      req_priority_req <= prio;
      req_slot <= s;
      req_remaining_time <= rem;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Sender gap of random length after a transaction.
   task automatic sender_gap(int idle_pct);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // Wait until every predicted result has arrived and the block has gone quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [sjs_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [sjs_pkg::TIME_W-1:0] val);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
   endtask

   // One random command, mostly select and requeue of running jobs.
   task automatic random_command(int idle_pct);
      int pick, k;
      logic [sjs_pkg::SLOT_W-1:0] s;
      logic [sjs_pkg::TIME_W-1:0] rem;
      logic [sjs_pkg::PRIO_W-1:0] prio;
      pick = $urandom_range(99);
      s = 6'($urandom_range(NUM_JOBS - 1));
      if (pick < 35) begin
         send_command(sjs_pkg::CMD_SELECT, 16'($urandom), 4'($urandom), 6'($urandom),
                      16'($urandom));
      end else if (pick < 65) begin
         if (running_slots.size() != 0) begin
            k = $urandom_range(running_slots.size() - 1);
            s = running_slots[k];
            running_slots.delete(k);
         end
         // Mostly a plausible leftover, sometimes an overcharge.
         if ($urandom_range(9) == 0) rem = 16'($urandom);
         else rem = 16'($urandom_range(sb.job_grant[s]));
         send_command(sjs_pkg::CMD_REQUEUE, 16'($urandom), 4'($urandom), s, rem);
      end else if (pick < 90) begin
         prio = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(10));
         send_command(sjs_pkg::CMD_ADD, 16'($urandom), prio, s, 16'($urandom));
      end else begin
         send_command(sjs_pkg::CMD_REMOVE, 16'($urandom), 4'($urandom), s, 16'($urandom));
      end
      sender_gap(idle_pct);
   endtask

   // Run limit.
   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int quanta[6], budgets[6], sender_idle[6], recv_stall[6];
      quanta  = '{100, 1, 65535, 37, 250, 9};
      budgets = '{500, 1, 65535, 900, 120, 4000};
      sender_idle = '{0, 83, 0, 36, 0, 83};
      recv_stall  = '{0, 0, 83, 36, 0, 83};
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = sjs_pkg::CMD_ADD;
      req_pid = '0;
      req_priority_req = '0;
      req_slot = '0;
      req_remaining_time = '0;
      csr_valid = 1'b0;
      csr_index = sjs_pkg::CSR_QUANTUM;
      csr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Idle select on an empty scheduler swaps and finds nothing.
      send_command(sjs_pkg::CMD_SELECT, '0, '0, '0, '0);
      // Fill the job table so that every entry and every link is written.
      for (int s = 0; s < NUM_JOBS; s++)
         send_command(sjs_pkg::CMD_ADD, 16'(s * 1021), 4'd1, 6'(s), '0);
      send_command(sjs_pkg::CMD_ADD, 16'hFFFF, 4'd0, 6'd0, 16'hFFFF);
      // Field extremes, priority saturation and the priority mapping.
      send_command(sjs_pkg::CMD_ADD, 16'h0000, 4'd15, 6'd63, '0);
      send_command(sjs_pkg::CMD_ADD, 16'hFFFF, 4'd10, 6'd1, '0);
      send_command(sjs_pkg::CMD_ADD, 16'hA5A5, 4'd2, 6'd2, '0);
      repeat (4) send_command(sjs_pkg::CMD_SELECT, '0, '0, '0, '0);
      // Requeue with nothing left, with a full leftover and with an overcharge.
      send_command(sjs_pkg::CMD_REQUEUE, '0, '0, 6'd0, '0);
      send_command(sjs_pkg::CMD_REQUEUE, '0, '0, 6'd1, 16'd100);
      send_command(sjs_pkg::CMD_REQUEUE, '0, '0, 6'd2, 16'hFFFF);
      send_command(sjs_pkg::CMD_REMOVE, '0, '0, 6'd3, '0);
      // Requeue one job at the bottom level repeatedly.
      for (int k = 0; k < 22; k++) send_command(sjs_pkg::CMD_REQUEUE, '0, '0, 6'd63, 16'd1);
      // Overfill the bottom queue to reach the count limit.
      for (int k = 0; k < 130; k++)
         send_command(sjs_pkg::CMD_ADD, 16'h1234, 4'd15, 6'd5, '0);
      repeat (3) send_command(sjs_pkg::CMD_SELECT, '0, '0, '0, '0);
      drain_results();

      // Random phases across register settings and idling patterns.
      for (int ph = 0; ph < 6; ph++) begin
         write_register(sjs_pkg::CSR_QUANTUM, 16'(quanta[ph]));
         write_register(sjs_pkg::CSR_LEVEL_BUDGET, 16'(budgets[ph]));
         stall_pct = recv_stall[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Long receiver hold-off so the block backs up onto its input.
            if (ph == 0 && n == 40) hold_cycles = 600;
            // Sender pause until every result is in.
            if (ph == 2 && n == 90) begin
               req_valid <= 1'b0;
               while (sb.due.size() != 0) @(posedge clock);
            end
            random_command(sender_idle[ph]);
         end
         drain_results();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
